@@ design/tirs_pkg.sv @@
package tirs_pkg;

	localparam logic [7:0] MFG_MARKER = 8'h55;
	localparam logic [7:0] RUN_MAX    = 8'hFF;

	localparam logic [7:0]  THRESHOLD_RST   = 8'd3;
	localparam logic [7:0]  LIMIT_RST       = 8'd3;
	localparam logic [15:0] RESET_MASK_RST  = 16'h0080;
	localparam logic [15:0] ATI_MASK_RST    = 16'h0008;
	localparam logic [15:0] FINGER_MASK_RST = 16'h0004;

	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 3;

	typedef enum logic [1:0] {
		MODE_IRQ        = 2'd0,
		MODE_CONFIGURE  = 2'd1,
		MODE_DEACTIVATE = 2'd2,
		MODE_RESUME     = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		ACT_NONE          = 4'd0,
		ACT_WRITE_CONFIG  = 4'd1,
		ACT_REATI         = 4'd2,
		ACT_CLOSE_SCHED   = 4'd3,
		ACT_RESEED        = 4'd4,
		ACT_DELIVER       = 4'd5,
		ACT_SUSPEND_CLOSE = 4'd6,
		ACT_CLOSE         = 4'd7,
		ACT_CFG_FAIL      = 4'd8
	} action_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_THRESHOLD   = 3'd0,
		REG_LIMIT       = 3'd1,
		REG_RESET_MASK  = 3'd2,
		REG_ATI_MASK    = 3'd3,
		REG_FINGER_MASK = 3'd4
	} reg_index_t;

	typedef struct packed {
		mode_t       mode;
		logic [15:0] irq_flags;
		logic [7:0]  mfg_marker;
		logic        read_ok;
		logic        write_ok;
		logic        open_ok;
		logic        schedule_ok;
		logic        sink_present;
	} in_item_t;

	typedef struct packed {
		logic        status;
		action_t     action;
		logic        end_session;
		logic        is_configured;
		logic        is_restart_pending;
		logic [7:0]  error_count;
		logic [7:0]  restart_count;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  restart_threshold;
		logic [7:0]  restart_limit;
		logic [15:0] reset_flag_mask;
		logic [15:0] ati_error_mask;
		logic [15:0] finger_overflow_mask;
	} cfg_t;

	typedef struct packed {
		logic       configured;
		logic       pending;
		logic [7:0] error_run;
		logic [7:0] restarts;
	} sup_state_t;

endpackage

@@ design/tirs_cfg_regs.sv @@
module tirs_cfg_regs
	import tirs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   we,
	input  logic [CFG_INDEX_W-1:0] index,
	input  logic [CFG_DATA_W-1:0]  data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.restart_threshold    <= THRESHOLD_RST;
			cfg_q.restart_limit        <= LIMIT_RST;
			cfg_q.reset_flag_mask      <= RESET_MASK_RST;
			cfg_q.ati_error_mask       <= ATI_MASK_RST;
			cfg_q.finger_overflow_mask <= FINGER_MASK_RST;
		end else if (we) begin
			unique case (reg_index_t'(index))
				REG_THRESHOLD:   cfg_q.restart_threshold    <= data[7:0];
				REG_LIMIT:       cfg_q.restart_limit        <= data[7:0];
				REG_RESET_MASK:  cfg_q.reset_flag_mask      <= data;
				REG_ATI_MASK:    cfg_q.ati_error_mask       <= data;
				REG_FINGER_MASK: cfg_q.finger_overflow_mask <= data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ design/tirs_decide.sv @@
module tirs_decide
	import tirs_pkg::*;
(
	input  in_item_t   item,
	input  sup_state_t cur,
	input  cfg_t       cfg,
	output sup_state_t nxt,
	output out_item_t  res
);

	logic       factory;
	logic [7:0] run_inc;
	logic       below_limit;
	logic       err;
	logic       endc;
	action_t    act;

	assign factory     = item.mfg_marker == MFG_MARKER;
	assign run_inc     = (cur.error_run == RUN_MAX) ? cur.error_run : cur.error_run + 8'd1;
	assign below_limit = cur.restarts < cfg.restart_limit;

	always_comb begin
		nxt  = cur;
		err  = 1'b0;
		endc = 1'b0;
		act  = ACT_NONE;
		unique case (item.mode)
			MODE_IRQ: begin
				if (!cur.configured || cur.pending || !item.read_ok || !item.write_ok) begin
					err = 1'b1;
				end else begin
					if ((item.irq_flags & cfg.reset_flag_mask) != '0) begin
						act = ACT_WRITE_CONFIG;
					end else if ((item.irq_flags & cfg.ati_error_mask) != '0 && !factory) begin
						nxt.error_run = run_inc;
						if (run_inc < cfg.restart_threshold && below_limit) begin
							act = ACT_REATI;
						end else if (below_limit) begin
							// hardware restart: close and ask for a delayed reopen
							act            = ACT_CLOSE_SCHED;
							nxt.restarts   = cur.restarts + 8'd1;
							nxt.error_run  = '0;
							nxt.configured = 1'b0;
							nxt.pending    = item.schedule_ok;
							err            = !item.schedule_ok;
						end
					end else begin
						if (!factory) begin
							nxt.error_run = '0;
							nxt.restarts  = '0;
						end
						if ((item.irq_flags & cfg.finger_overflow_mask) != '0)
							act = ACT_RESEED;
						else if (item.sink_present)
							act = ACT_DELIVER;
					end
					endc = !err && !nxt.pending;
				end
			end
			MODE_CONFIGURE, MODE_RESUME: begin
				if (item.mode == MODE_RESUME && !cur.pending) begin
					err = 1'b1;
				end else begin
					nxt.pending = 1'b0;
					if (!item.open_ok) begin
						err = 1'b1;
					end else if (!item.write_ok) begin
						nxt.configured = 1'b0;
						err            = 1'b1;
						act            = ACT_CFG_FAIL;
					end else begin
						nxt.configured = 1'b1;
						act            = ACT_WRITE_CONFIG;
					end
					// a configure event leaves the pending flag alone
					if (item.mode == MODE_CONFIGURE)
						nxt.pending = cur.pending;
				end
			end
			MODE_DEACTIVATE: begin
				if (cur.configured) begin
					act  = ACT_SUSPEND_CLOSE;
					err  = !item.read_ok || !item.write_ok;
					endc = item.read_ok && item.write_ok;
				end else begin
					act = ACT_CLOSE;
				end
				nxt = '0;
			end
			default: ;
		endcase

		res.status             = err;
		res.action             = act;
		res.end_session        = endc;
		res.is_configured      = nxt.configured;
		res.is_restart_pending = nxt.pending;
		res.error_count        = nxt.error_run;
		res.restart_count      = nxt.restarts;
	end

endmodule

@@ design/touch_irq_recovery_supervisor.sv @@
// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+------------------------------
// event in  | input     | in_valid / in_ready   | in_item  (tirs_pkg::in_item_t)
// result    | output    | out_valid / out_ready | out_item (tirs_pkg::out_item_t)
// config    | input     | cfg_we (no wait)      | cfg_index, cfg_data
//
// one event beat per cycle sustained while out_ready holds; the decision stage sits between
// the input and result registers: supervisor state is read and written back in the same
// cycle the item moves from the input register to the result register
// arst_n clears both valid flags and supervisor state and sets config registers to their defaults
// a stalled result holds in the output register while the input register still
// takes a beat; both sides stall only when both registers are full
module touch_irq_recovery_supervisor
	import tirs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  in_item_t               in_item,
	output logic                   out_valid,
	input  logic                   out_ready,
	output out_item_t              out_item,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// input register
	logic      valid_s1;
	in_item_t  item_s1;

	// result register
	logic      valid_s2;
	out_item_t res_s2;

	// supervisor state, advanced once per event
	sup_state_t state_q;
	sup_state_t state_nxt;
	out_item_t  res_nxt;
	cfg_t       cfg;

	logic advance;
	logic take_in;

	// event moves on when the result register is empty or being drained
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	// input register frees up in the same cycle it hands its beat over
	assign in_ready = !valid_s1 || advance;
	assign take_in  = in_valid && in_ready;

	tirs_cfg_regs u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (cfg_we),
		.index (cfg_index),
		.data  (cfg_data),
		.cfg   (cfg)
	);

	tirs_decide u_decide (
		.item(item_s1),
		.cur (state_q),
		.cfg (cfg),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (take_in)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;

			if (advance)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;

			// state commits together with the result of the same event
			if (advance)
				state_q <= state_nxt;
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (take_in)
			item_s1 <= in_item;
		if (advance)
			res_s2 <= res_nxt;
	end

	assign out_valid = valid_s2;
	assign out_item  = res_s2;

endmodule

@@ design/tirs_checker.sv @@
module tirs_checker
	import tirs_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_item
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result beat changed while stalled");

	// end of session never goes with an error
	a_endc_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_item.status && out_item.end_session))
		else $error("end_session with error status");

	// a pending restart never ends the session
	a_pending_no_endc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.is_restart_pending |-> !out_item.end_session)
		else $error("end_session while restart pending");

	// close and schedule leaves the device unconfigured
	a_sched_unconf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.action == ACT_CLOSE_SCHED |-> !out_item.is_configured)
		else $error("configured after close and schedule");

	// deactivate clears everything
	a_deact_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.action == ACT_SUSPEND_CLOSE || out_item.action == ACT_CLOSE)
		|-> !out_item.is_configured && !out_item.is_restart_pending
		&& out_item.error_count == 8'd0 && out_item.restart_count == 8'd0)
		else $error("state not cleared on deactivate");

endmodule

bind touch_irq_recovery_supervisor tirs_checker u_tirs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_item (out_item)
);
